// ----- rtl/byte_packetizer_with_idle_flush_assert.svh -----
`ifndef BYTE_PACKETIZER_WITH_IDLE_FLUSH_ASSERT_SVH
`define BYTE_PACKETIZER_WITH_IDLE_FLUSH_ASSERT_SVH

// same-cycle implication
`define BPK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BPK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/bpk_pkg.sv -----
package bpk_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_SEND = 2'd2;

    localparam logic [1:0] CFG_TYPE_CODE  = 2'd0;
    localparam logic [1:0] CFG_IDLE_FLUSH = 2'd1;

    localparam logic [6:0] IDLE_LIMIT = 7'd100;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLOSE_DATA,
        ST_CLOSE_SEND,
        ST_SEND_CHECK,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic byte_wr;
        logic tick;
        logic close;
        logic send_rd;
        logic send_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic byte_fills;
        logic flush_due;
        logic queued;
        logic send_last;
    } dp_status_t;

endpackage

// ----- rtl/byte_packetizer_with_idle_flush.sv -----
// Data byte and tick: busy stays low, but a byte that completes a packet also passes
// through CLOSE_DATA (length write). Send: enters SEND, via CLOSE_SEND and SEND_CHECK
// with an idle flush; then PACKET_BYTES bytes on consecutive cycles, paced by the
// single store read port. The receiver cannot stall; each byte is valid for one cycle
// with strobe. After reset, busy stays high while the SLOT_COUNT*PACKET_BYTES store
// bytes (320 by default) are cleared one per cycle; config writes are still taken.
module byte_packetizer_with_idle_flush #(
    parameter int PACKET_BYTES = 64,
    parameter int DATA_BYTES   = 60,
    parameter int SLOT_COUNT   = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic       last
);

    bpk_pkg::ctrl_cmd_t  cmd;
    bpk_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    bpk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bpk_datapath #(
        .PACKET_BYTES (PACKET_BYTES),
        .DATA_BYTES   (DATA_BYTES),
        .SLOT_COUNT   (SLOT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .data_byte (data_byte),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// ----- rtl/bpk_ctrl.sv -----
module bpk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         kind,
    input  bpk_pkg::dp_status_t status,
    output bpk_pkg::ctrl_cmd_t cmd,
    output logic               busy
);

    bpk_pkg::state_t state_reg;
    bpk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpk_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            bpk_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = bpk_pkg::ST_IDLE;
                end
            end
            bpk_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (kind)
                        bpk_pkg::KIND_DATA:
                        begin
                            cmd.byte_wr = 1'b1;
                            if (status.byte_fills)
                            begin
                                state_next = bpk_pkg::ST_CLOSE_DATA;
                            end
                        end
                        bpk_pkg::KIND_TICK:
                        begin
                            cmd.tick = 1'b1;
                        end
                        bpk_pkg::KIND_SEND:
                        begin
                            priority if (status.flush_due)
                            begin
                                state_next = bpk_pkg::ST_CLOSE_SEND;
                            end
                            else if (status.queued)
                            begin
                                state_next = bpk_pkg::ST_SEND;
                            end
                            else
                            begin
                                state_next = bpk_pkg::ST_IDLE;
                            end
                        end
                        default:
                        begin
                            state_next = bpk_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bpk_pkg::ST_CLOSE_DATA:
            begin
                cmd.close  = 1'b1;
                state_next = bpk_pkg::ST_IDLE;
            end
            bpk_pkg::ST_CLOSE_SEND:
            begin
                cmd.close  = 1'b1;
                state_next = bpk_pkg::ST_SEND_CHECK;
            end
            bpk_pkg::ST_SEND_CHECK:
            begin
                state_next = status.queued ? bpk_pkg::ST_SEND : bpk_pkg::ST_IDLE;
            end
            bpk_pkg::ST_SEND:
            begin
                cmd.send_rd = 1'b1;
                if (status.send_last)
                begin
                    cmd.send_end = 1'b1;
                    state_next   = bpk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bpk_datapath.sv -----
`include "byte_packetizer_with_idle_flush_assert.svh"

module bpk_datapath #(
    parameter int PACKET_BYTES = 64,
    parameter int DATA_BYTES   = 60,
    parameter int SLOT_COUNT   = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpk_pkg::ctrl_cmd_t  cmd,
    output bpk_pkg::dp_status_t status,
    input  logic [7:0]          data_byte,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output logic                strobe,
    output logic [7:0]          out_byte,
    output logic                last
);

    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int FILL_W     = $clog2(DATA_BYTES + 1);
    localparam int POS_W      = $clog2(PACKET_BYTES);
    localparam int WPOS_W     = $clog2(DATA_BYTES + 3);
    localparam int STORE_SIZE = SLOT_COUNT * PACKET_BYTES;
    localparam int MEM_AW     = $clog2(STORE_SIZE);
    localparam int WIDE_W     = $clog2(STORE_SIZE + DATA_BYTES + 2) + 1;

    logic [7:0]        mem [STORE_SIZE];
    logic [7:0]        rdata_reg;

    logic [SLOT_W-1:0] write_slot_reg;
    logic [SLOT_W-1:0] read_slot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [6:0]        idle_reg;
    logic [7:0]        type_code_reg;
    logic [6:0]        idle_thr_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [POS_W-1:0]  send_pos_reg;
    logic              strobe_reg;
    logic [POS_W-1:0]  pos_d_reg;

    logic [SLOT_W-1:0] write_slot_inc;
    logic [SLOT_W-1:0] read_slot_inc;
    logic [WPOS_W-1:0] wpos;
    logic [WIDE_W-1:0] wbase;
    logic [WIDE_W-1:0] rbase;
    logic [WIDE_W-1:0] byte_addr_w;
    logic [WIDE_W-1:0] len_addr_w;
    logic [WIDE_W-1:0] rd_addr_w;
    logic              byte_in_range;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    assign write_slot_inc = (write_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                            '0 : write_slot_reg + SLOT_W'(1);
    assign read_slot_inc  = (read_slot_reg == SLOT_W'(SLOT_COUNT - 1)) ?
                            '0 : read_slot_reg + SLOT_W'(1);

    assign wpos          = WPOS_W'(fill_reg) + WPOS_W'(2);
    assign byte_in_range = int'(wpos) < PACKET_BYTES;
    assign wbase         = WIDE_W'(write_slot_reg) * WIDE_W'(PACKET_BYTES);
    assign rbase         = WIDE_W'(read_slot_reg) * WIDE_W'(PACKET_BYTES);
    assign byte_addr_w   = wbase + WIDE_W'(wpos);
    assign len_addr_w    = wbase + WIDE_W'(1);
    assign rd_addr_w     = rbase + WIDE_W'(send_pos_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 8'd0;
        priority if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.byte_wr)
        begin
            mem_we    = byte_in_range;
            mem_waddr = byte_addr_w[MEM_AW-1:0];
            mem_wdata = data_byte;
        end
        else if (cmd.close)
        begin
            mem_we    = 1'b1;
            mem_waddr = len_addr_w[MEM_AW-1:0];
            mem_wdata = 8'(fill_reg);
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr_w[MEM_AW-1:0]];
        pos_d_reg <= send_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            fill_reg       <= '0;
            idle_reg       <= '0;
            type_code_reg  <= 8'd1;
            idle_thr_reg   <= 7'd2;
            clr_cnt_reg    <= '0;
            send_pos_reg   <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.send_rd;
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (cfg_we && cfg_index == bpk_pkg::CFG_TYPE_CODE)
            begin
                type_code_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == bpk_pkg::CFG_IDLE_FLUSH)
            begin
                idle_thr_reg <= cfg_data[6:0];
            end
            if (cmd.byte_wr)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
                idle_reg <= '0;
            end
            if (cmd.tick && idle_reg < bpk_pkg::IDLE_LIMIT)
            begin
                idle_reg <= idle_reg + 7'd1;
            end
            if (cmd.close)
            begin
                fill_reg <= '0;
                if (write_slot_inc != read_slot_reg)
                begin
                    write_slot_reg <= write_slot_inc;
                end
            end
            if (cmd.send_end)
            begin
                send_pos_reg  <= '0;
                read_slot_reg <= read_slot_inc;
            end
            else if (cmd.send_rd)
            begin
                send_pos_reg <= send_pos_reg + POS_W'(1);
            end
        end
    end

    assign status.clear_last = clr_cnt_reg == MEM_AW'(STORE_SIZE - 1);
    assign status.byte_fills = ((FILL_W + 1)'(fill_reg) + (FILL_W + 1)'(1)) >=
                               (FILL_W + 1)'(DATA_BYTES);
    assign status.flush_due  = (fill_reg != '0) && (idle_reg > idle_thr_reg);
    assign status.queued     = read_slot_reg != write_slot_reg;
    assign status.send_last  = send_pos_reg == POS_W'(PACKET_BYTES - 1);

    assign strobe   = strobe_reg;
    assign out_byte = (pos_d_reg == '0) ? type_code_reg : rdata_reg;
    assign last     = pos_d_reg == POS_W'(PACKET_BYTES - 1);

    `BPK_ASSERT_NOW(a_idle_sat, clk, rst_n, 1'b1, idle_reg <= bpk_pkg::IDLE_LIMIT)
    `BPK_ASSERT_NOW(a_fill_max, clk, rst_n, 1'b1, int'(fill_reg) <= DATA_BYTES)
    `BPK_ASSERT_NEXT(a_read_strobe, clk, rst_n, cmd.send_rd, strobe_reg)
    `BPK_ASSERT_NEXT(a_close_empties, clk, rst_n, cmd.close, fill_reg == '0)

endmodule

// ----- verif/bpk_packet_checker.sv -----
module bpk_packet_checker #(
    parameter int PACKET_BYTES = 64,
    parameter int DATA_BYTES   = 60,
    parameter int SLOT_COUNT   = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       strobe,
    input  logic [7:0] out_byte,
    input  logic       last,
    output int         pending,
    output int         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } tx_byte_t;

    tx_byte_t   tx_bytes_due[$];
    logic [7:0] slot_mem [SLOT_COUNT*PACKET_BYTES];
    int         wr_slot;
    int         rd_slot;
    int         fill_pos;
    logic [6:0] idle_ticks;
    logic [7:0] type_code;
    logic [6:0] flush_ticks;
    int         errors;

    function automatic int next_slot(input int s);
        return (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
    endfunction

    task automatic close_fill();
        int len;
        int n;
        len = (fill_pos > DATA_BYTES) ? DATA_BYTES : fill_pos;
        slot_mem[wr_slot*PACKET_BYTES + 1] = 8'(len);
        n = next_slot(wr_slot);
        if (n != rd_slot)
        begin
            wr_slot = n;
        end
        fill_pos = 0;
    endtask

    task automatic predict_item(input logic [1:0] k, input logic [7:0] b);
        tx_byte_t t;
        int       i;
        case (k)
            bpk_pkg::KIND_DATA:
            begin
                slot_mem[wr_slot*PACKET_BYTES + 2 + fill_pos] = b;
                fill_pos++;
                if (fill_pos >= DATA_BYTES)
                begin
                    close_fill();
                end
                idle_ticks = '0;
            end
            bpk_pkg::KIND_TICK:
            begin
                if (idle_ticks < bpk_pkg::IDLE_LIMIT)
                begin
                    idle_ticks++;
                end
            end
            bpk_pkg::KIND_SEND:
            begin
                if (fill_pos > 0 && idle_ticks > flush_ticks)
                begin
                    close_fill();
                end
                if (rd_slot != wr_slot)
                begin
                    slot_mem[rd_slot*PACKET_BYTES] = type_code;
                    for (i = 0; i < PACKET_BYTES; i++)
                    begin
                        t.value = slot_mem[rd_slot*PACKET_BYTES + i];
                        t.last  = (i == PACKET_BYTES - 1);
                        tx_bytes_due.push_back(t);
                    end
                    rd_slot = next_slot(rd_slot);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_mem[j])
            begin
                slot_mem[j] = '0;
            end
            tx_bytes_due.delete();
            wr_slot     = 0;
            rd_slot     = 0;
            fill_pos    = 0;
            idle_ticks  = '0;
            type_code   = 8'd1;
            flush_ticks = 7'd2;
            errors      = 0;
            pending     = 0;
            fail_count  = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (tx_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual out_byte %02h last %0b",
                             $time, out_byte, last);
                    errors++;
                end
                else
                begin
                    tx_byte_t exp_byte;
                    exp_byte = tx_bytes_due.pop_front();
                    if (out_byte !== exp_byte.value)
                    begin
                        $display("%0t: out_byte expected %02h, actual %02h",
                                 $time, exp_byte.value, out_byte);
                        errors++;
                    end
                    if (last !== exp_byte.last)
                    begin
                        $display("%0t: last expected %0b, actual %0b",
                                 $time, exp_byte.last, last);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bpk_pkg::CFG_TYPE_CODE:  type_code   = cfg_data;
                    bpk_pkg::CFG_IDLE_FLUSH: flush_ticks = cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
            if (start && !busy)
            begin
                predict_item(kind, data_byte);
            end
            pending    = tx_bytes_due.size();
            fail_count = errors;
        end
    end

endmodule

// ----- verif/tb_byte_packetizer_with_idle_flush.sv -----
module tb_byte_packetizer_with_idle_flush;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PKT_BYTES  = 64;
    localparam int DATA_BYTES = 60;
    localparam int SLOTS      = 5;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int GAP_PCT    = 35;
    localparam int DRAIN_HOLD = 8;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    logic [1:0] kind      = bpk_pkg::KIND_DATA;
    logic [7:0] data_byte = 8'd0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = bpk_pkg::CFG_TYPE_CODE;
    logic [7:0] cfg_data  = 8'd0;
    logic       strobe;
    logic [7:0] out_byte;
    logic       last;

    int pending;
    int fail_count;
    int n_items;
    bit gaps_on;

    byte_packetizer_with_idle_flush #(
        .PACKET_BYTES(PKT_BYTES),
        .DATA_BYTES  (DATA_BYTES),
        .SLOT_COUNT  (SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .data_byte(data_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .strobe   (strobe),
        .out_byte (out_byte),
        .last     (last)
    );

    bpk_packet_checker #(
        .PACKET_BYTES(PKT_BYTES),
        .DATA_BYTES  (DATA_BYTES),
        .SLOT_COUNT  (SLOTS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .out_byte  (out_byte),
        .last      (last),
        .pending   (pending),
        .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic issue(input logic [1:0] k, input logic [7:0] b);
        if (gaps_on && $urandom_range(99) < GAP_PCT)
        begin
            start     <= 1'b0;
            kind      <= 2'($urandom);
            data_byte <= 8'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < GAP_PCT)
            begin
                @(posedge clk);
            end
        end
        start     <= 1'b1;
        kind      <= k;
        data_byte <= b;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        n_items++;
    endtask

    // hold off until every queued packet byte has gone out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_HOLD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic partial_packet(input int max_bytes, input int tick_lo, input int tick_hi);
        repeat ($urandom_range(max_bytes, 1)) issue(bpk_pkg::KIND_DATA, 8'($urandom));
        repeat ($urandom_range(tick_hi, tick_lo)) issue(bpk_pkg::KIND_TICK, 8'($urandom));
        issue(bpk_pkg::KIND_SEND, 8'($urandom));
    endtask

    task automatic run_episodes(input int target, input int tick_lo, input int tick_hi);
        int first;
        first = n_items;
        while (n_items - first < target)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: partial_packet(8, tick_lo, tick_hi);
                5: partial_packet(24, tick_lo, tick_hi);
                6, 7:
                begin
                    repeat ($urandom_range(5, 1))
                    begin
                        issue(2'($urandom), 8'($urandom));
                    end
                end
                8: issue(bpk_pkg::KIND_SEND, 8'($urandom));
                default: partial_packet(16, 0, tick_hi);
            endcase
        end
    endtask

    initial
    begin
        logic [6:0] thr;
        logic [7:0] thr_wr;
        gaps_on = 1'b1;
        n_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(bpk_pkg::KIND_SEND, 8'h00);
        issue(KIND_UNUSED, 8'hFF);
        issue(bpk_pkg::KIND_DATA, 8'h00);
        issue(bpk_pkg::KIND_DATA, 8'hFF);
        issue(bpk_pkg::KIND_DATA, 8'hA5);
        repeat (3) issue(bpk_pkg::KIND_TICK, 8'h00);
        issue(bpk_pkg::KIND_SEND, 8'h00);
        issue(bpk_pkg::KIND_TICK, 8'hFF);
        issue(bpk_pkg::KIND_SEND, 8'h00);
        issue(bpk_pkg::KIND_DATA, 8'h5A);
        repeat (2) issue(bpk_pkg::KIND_TICK, 8'h00);
        issue(bpk_pkg::KIND_SEND, 8'hFF);
        issue(bpk_pkg::KIND_TICK, 8'h00);
        issue(bpk_pkg::KIND_SEND, 8'h00);
        drain();

        write_reg(bpk_pkg::CFG_TYPE_CODE, 8'h00);
        write_reg(bpk_pkg::CFG_IDLE_FLUSH, 8'h00);
        cfg_valid <= 1'b0;
        run_episodes(20, 0, 3);
        drain();

        write_reg(bpk_pkg::CFG_TYPE_CODE, 8'hFF);
        write_reg(bpk_pkg::CFG_IDLE_FLUSH, 8'd99);
        cfg_valid <= 1'b0;
        gaps_on = 1'b0;
        repeat (DATA_BYTES + 2) issue(bpk_pkg::KIND_DATA, 8'($urandom));
        repeat (2) issue(bpk_pkg::KIND_SEND, 8'($urandom));
        gaps_on = 1'b1;
        drain();

        write_reg(bpk_pkg::CFG_TYPE_CODE, 8'($urandom));
        write_reg(CFG_SPARE_2, 8'($urandom));
        write_reg(CFG_SPARE_3, 8'($urandom));
        write_reg(bpk_pkg::CFG_IDLE_FLUSH, 8'hFF);
        cfg_valid <= 1'b0;
        run_episodes(12, 0, 4);
        drain();

        thr    = 7'($urandom_range(6));
        thr_wr = {1'($urandom), thr};
        write_reg(bpk_pkg::CFG_TYPE_CODE, 8'($urandom));
        write_reg(bpk_pkg::CFG_IDLE_FLUSH, thr_wr);
        cfg_valid <= 1'b0;
        run_episodes(12, 0, int'(thr) + 3);
        drain();

        write_reg(bpk_pkg::CFG_TYPE_CODE, 8'd1);
        write_reg(bpk_pkg::CFG_IDLE_FLUSH, 8'd2);
        cfg_valid <= 1'b0;
        run_episodes(12, 0, 5);
        drain();

        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
